/* rtl/lip_pkg.sv */
`default_nettype none
package lip_pkg;

  // coordinate format on the ports: two's complement, fixed width
  localparam int COORD_W = 32;
  // width of the parallel tolerance register
  localparam int TOL_W   = 32;

  typedef struct packed {
    logic [COORD_W-1:0] a_start_x;
    logic [COORD_W-1:0] a_start_y;
    logic [COORD_W-1:0] a_end_x;
    logic [COORD_W-1:0] a_end_y;
    logic [COORD_W-1:0] b_start_x;
    logic [COORD_W-1:0] b_start_y;
    logic [COORD_W-1:0] b_end_x;
    logic [COORD_W-1:0] b_end_y;
  } query_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] cross_x;
    logic [COORD_W-1:0] cross_y;
    logic               saturated;
  } result_t;

endpackage
`default_nettype wire

/* rtl/line_intersection_point_2d.sv */
// Channel   Dir  Handshake                 Payload
// query     in   start, busy (always low)  lip_pkg::query_t, eight Q16.16 coordinates
// result    out  done, one-cycle strobe    lip_pkg::result_t
// cfg       in   cfg_valid, cfg_ready      cfg_data, parallel tolerance
//
// One item per cycle; done and the result are registered together, and the result is taken at
// the edge after done rises. The restoring divider resolves one quotient bit per stage for
// COORD_W + 1 stages.
// Synchronous active-high reset clears all stage valid bits and the tolerance.
// The result side cannot stall, so nothing in the pipe ever holds; busy stays low.
`default_nettype none
module line_intersection_point_2d #(
  parameter int FRAC_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire lip_pkg::query_t         query,
  output logic                         done,
  output lip_pkg::result_t             result,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [lip_pkg::TOL_W-1:0]     cfg_data
);
  import lip_pkg::*;

  localparam int CW   = COORD_W;
  localparam int DW   = CW + 1;            // coordinate differences
  localparam int PW   = 2 * DW + 1;        // dem, num
  localparam int LW   = (PW + 1) / 2;      // low split of |num|
  localparam int HW   = PW - LW;           // high split of |num|
  localparam int MW   = PW + DW;           // |num * d|
  localparam int QW   = CW + 1;            // quotient bits kept
  localparam int TSW  = TOL_W + FRAC_BITS;
  localparam int CMPW = ((PW > TSW) ? PW : TSW) + 1;
  localparam int LAT  = 8 + QW;            // accepting edge to the edge that takes done

  typedef struct packed {
    logic [PW-1:0]        rem;
    logic [QW-1:0]        qr;
    logic                 ovf;
    logic                 neg;
    logic signed [CW-1:0] p;
  } lane_t;

  typedef struct packed {
    logic          valid;
    logic          par;
    logic [PW-1:0] adem;
  } ctl_t;

  // configuration
  logic [TOL_W-1:0] tolerance;
  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  logic accept;
  assign accept = start && !busy;

  // stage 1: differences
  logic                 v1;
  logic signed [DW-1:0] dx1, dy1, ex1, ey1, wx1, wy1;
  logic signed [CW-1:0] px1, py1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    dx1 <= $signed({query.a_end_x[CW-1], query.a_end_x})
         - $signed({query.a_start_x[CW-1], query.a_start_x});
    dy1 <= $signed({query.a_end_y[CW-1], query.a_end_y})
         - $signed({query.a_start_y[CW-1], query.a_start_y});
    ex1 <= $signed({query.b_end_x[CW-1], query.b_end_x})
         - $signed({query.b_start_x[CW-1], query.b_start_x});
    ey1 <= $signed({query.b_end_y[CW-1], query.b_end_y})
         - $signed({query.b_start_y[CW-1], query.b_start_y});
    wx1 <= $signed({query.b_start_x[CW-1], query.b_start_x})
         - $signed({query.a_start_x[CW-1], query.a_start_x});
    wy1 <= $signed({query.b_start_y[CW-1], query.b_start_y})
         - $signed({query.a_start_y[CW-1], query.a_start_y});
    px1 <= $signed(query.a_start_x);
    py1 <= $signed(query.a_start_y);
  end

  // stage 2: cross products
  logic                   v2;
  logic signed [2*DW-1:0] m_eydx, m_exdy, m_eywx, m_exwy;
  logic signed [DW-1:0]   dx2, dy2;
  logic signed [CW-1:0]   px2, py2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    m_eydx <= ey1 * dx1;
    m_exdy <= ex1 * dy1;
    m_eywx <= ey1 * wx1;
    m_exwy <= ex1 * wy1;
    dx2    <= dx1;
    dy2    <= dy1;
    px2    <= px1;
    py2    <= py1;
  end

  // stage 3: dem and num
  logic                 v3;
  logic signed [PW-1:0] dem3, num3;
  logic signed [DW-1:0] dx3, dy3;
  logic signed [CW-1:0] px3, py3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    dem3 <= $signed({m_eydx[2*DW-1], m_eydx}) - $signed({m_exdy[2*DW-1], m_exdy});
    num3 <= $signed({m_eywx[2*DW-1], m_eywx}) - $signed({m_exwy[2*DW-1], m_exwy});
    dx3  <= dx2;
    dy3  <= dy2;
    px3  <= px2;
    py3  <= py2;
  end

  // stage 4: magnitudes, quotient signs, parallel test
  logic                 v4, par4, negx4, negy4;
  logic [PW-1:0]        adem4, anum4;
  logic [DW-1:0]        adx4, ady4;
  logic signed [CW-1:0] px4, py4;
  logic [PW-1:0]        adem3;
  logic [CMPW-1:0]      tol_cmp;

  assign adem3   = dem3[PW-1] ? (~dem3 + 1'b1) : dem3;
  assign tol_cmp = CMPW'({tolerance, {FRAC_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    adem4 <= adem3;
    anum4 <= num3[PW-1] ? (~num3 + 1'b1) : num3;
    adx4  <= dx3[DW-1] ? (~dx3 + 1'b1) : dx3;
    ady4  <= dy3[DW-1] ? (~dy3 + 1'b1) : dy3;
    negx4 <= num3[PW-1] ^ dem3[PW-1] ^ dx3[DW-1];
    negy4 <= num3[PW-1] ^ dem3[PW-1] ^ dy3[DW-1];
    par4  <= (CMPW'(adem3) <= tol_cmp);
    px4   <= px3;
    py4   <= py3;
  end

  // stage 5: partial products of |num| * |d|
  logic                 v5, par5, negx5, negy5;
  logic [PW-1:0]        adem5;
  logic [LW+DW-1:0]     plx5, ply5;
  logic [HW+DW-1:0]     phx5, phy5;
  logic signed [CW-1:0] px5, py5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    plx5  <= anum4[LW-1:0] * adx4;
    phx5  <= anum4[PW-1:LW] * adx4;
    ply5  <= anum4[LW-1:0] * ady4;
    phy5  <= anum4[PW-1:LW] * ady4;
    par5  <= par4;
    adem5 <= adem4;
    negx5 <= negx4;
    negy5 <= negy4;
    px5   <= px4;
    py5   <= py4;
  end

  // stage 6: full product
  logic                 v6, par6, negx6, negy6;
  logic [PW-1:0]        adem6;
  logic [MW-1:0]        prx6, pry6;
  logic signed [CW-1:0] px6, py6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    prx6  <= MW'(plx5) + (MW'(phx5) << LW);
    pry6  <= MW'(ply5) + (MW'(phy5) << LW);
    par6  <= par5;
    adem6 <= adem5;
    negx6 <= negx5;
    negy6 <= negy5;
    px6   <= px5;
    py6   <= py5;
  end

  // stage 7: overflow check and divider load
  ctl_t  ctl  [QW+1];
  lane_t lx   [QW+1];
  lane_t ly   [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else begin
      ctl[0].valid <= v6;
    end
    ctl[0].par  <= par6;
    ctl[0].adem <= adem6;
    lx[0].rem   <= prx6[MW-1:QW];
    lx[0].qr    <= prx6[QW-1:0];
    lx[0].ovf   <= (prx6[MW-1:QW] >= adem6);
    lx[0].neg   <= negx6;
    lx[0].p     <= px6;
    ly[0].rem   <= pry6[MW-1:QW];
    ly[0].qr    <= pry6[QW-1:0];
    ly[0].ovf   <= (pry6[MW-1:QW] >= adem6);
    ly[0].neg   <= negy6;
    ly[0].p     <= py6;
  end

  // divider: one restoring step per stage
  function automatic lane_t div_step(lane_t l, logic [PW-1:0] d);
    logic [PW:0] t;
    logic        ge;
    lane_t       o;
    t     = {l.rem, l.qr[QW-1]};
    ge    = (t >= {1'b0, d});
    o     = l;
    o.rem = ge ? PW'(t - {1'b0, d}) : t[PW-1:0];
    o.qr  = {l.qr[QW-2:0], ge};
    return o;
  endfunction

  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1].valid <= 1'b0;
      end else begin
        ctl[k+1].valid <= ctl[k].valid;
      end
      ctl[k+1].par  <= ctl[k].par;
      ctl[k+1].adem <= ctl[k].adem;
      lx[k+1]       <= div_step(lx[k], ctl[k].adem);
      ly[k+1]       <= div_step(ly[k], ctl[k].adem);
    end
  end

  // final: signed add to the start point and clamp
  function automatic logic [CW:0] place(lane_t l);
    logic signed [CW+2:0] qs;
    logic signed [CW+2:0] sum;
    logic signed [CW+2:0] top;
    logic signed [CW+2:0] bot;
    logic [CW:0]          o;
    top = (CW+3)'((64'sd1 <<< (CW - 1)) - 1);
    bot = -top - 1;
    qs  = l.neg ? -$signed({2'b00, l.qr}) : $signed({2'b00, l.qr});
    sum = $signed({{3{l.p[CW-1]}}, l.p}) + qs;
    if (l.ovf) begin
      o = l.neg ? {1'b1, bot[CW-1:0]} : {1'b1, top[CW-1:0]};
    end else if (sum > top) begin
      o = {1'b1, top[CW-1:0]};
    end else if (sum < bot) begin
      o = {1'b1, bot[CW-1:0]};
    end else begin
      o = {1'b0, sum[CW-1:0]};
    end
    return o;
  endfunction

  logic [CW:0] fx, fy;
  assign fx = place(lx[QW]);
  assign fy = place(ly[QW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[QW].valid;
    end
    if (ctl[QW].par) begin
      result <= '0;
    end else begin
      result.found     <= 1'b1;
      result.cross_x   <= fx[CW-1:0];
      result.cross_y   <= fy[CW-1:0];
      result.saturated <= fx[CW] | fy[CW];
    end
  end

  // checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done) else $error("result strobe missing after item");
  a_zero_miss: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.cross_x == '0 && result.cross_y == '0
      && !result.saturated)) else $error("parallel result not cleared");
  a_sat_found: assert property (@(posedge clk) disable iff (rst)
    (done && result.saturated) |-> result.found) else $error("saturated without found");
  a_no_spur: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl[QW].valid))
    else $error("strobe without item");

endmodule
`default_nettype wire
